// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the formatter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ----- hw/rtl/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, character codes and helpers for the integer formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_UPPER_A = 7'h41;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_MINUS   = 7'h2D;

    localparam logic [4:0] RADIX_MIN = 5'd2;
    localparam logic [4:0] RADIX_MAX = 5'd16;
    localparam logic [4:0] RADIX_DEC = 5'd10;

    // Radix bits retired per division cycle.
    localparam int DIV_BITS_PER_CYC = 8;

    typedef struct packed {
        logic load;
        logic div_step;
        logic fetch;
        logic emit_sign;
        logic emit_pad;
        logic emit_digit;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;   // last division cycle of a digit, quotient is zero
        logic neg;
        logic pad_zero;
        logic idx_zero;
    } dp_stat_t;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + 7'(d);
        end
        else
        begin
            c = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + 7'(d) - 7'd10;
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/itoa_ctrl.sv -----
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: accept, digit division loop, digit fetch, then sign, pad, digits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_DIGIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = stat.neg ? S_SIGN : S_PAD;
            end
            S_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                state_next    = S_PAD;
            end
            S_PAD:
            begin
                if (stat.pad_zero)
                begin
                    state_next = S_DIGIT;
                end
                else
                begin
                    cmd.emit_pad = 1'b1;
                end
            end
            S_DIGIT:
            begin
                cmd.emit_digit = 1'b1;
                if (stat.idx_zero)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `ASSERT_IMPL(a_idle_quiet, clk, rst_n, state_reg == S_IDLE, !(cmd.div_step || cmd.fetch || cmd.emit_digit))
    `ASSERT_NEXT(a_load_divides, clk, rst_n, cmd.load, state_reg == S_DIV)
    `ASSERT_NEXT(a_sign_then_pad, clk, rst_n, cmd.emit_sign, state_reg == S_PAD)

endmodule

// ----- hw/rtl/itoa_datapath.sv -----
// ----------------------------------------------------------------------------
// itoa_datapath
// Radix divider (8 quotient bits per cycle), digit memory, character output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itoa_datapath
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_PAD    = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [4:0]            radix,
    input  logic                  signed_mode,
    input  logic                  upper_case,
    input  logic [4:0]            pad_width,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic [6:0]            ascii_char,
    output logic                  last,
    output logic                  strobe
);

    localparam int DIV_CYC = (VALUE_BITS + DIV_BITS_PER_CYC - 1) / DIV_BITS_PER_CYC;
    localparam int DW      = DIV_CYC * DIV_BITS_PER_CYC;
    localparam int SW      = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam int AW      = $clog2(VALUE_BITS);
    localparam int CW      = $clog2(VALUE_BITS + 1);
    localparam int PW      = $clog2(MAX_PAD + 1);
    localparam int LW      = ((CW > PW) ? CW : PW) + 1;

    logic [DW-1:0]         mag_reg;
    logic [3:0]            rem_reg;
    logic [4:0]            base_reg;
    logic                  neg_reg;
    logic                  upper_reg;
    logic [PW-1:0]         pad_reg;
    logic [SW-1:0]         step_reg;
    logic [CW-1:0]         nd_reg;
    logic [AW-1:0]         rd_idx_reg;
    logic [PW-1:0]         pad_cnt_reg;
    logic [3:0]            rd_data_reg;
    logic [6:0]            char_reg;
    logic                  last_reg;
    logic                  strobe_reg;
    logic [3:0]            dig_mem [VALUE_BITS];

    logic [DW-1:0]         mag_next;
    logic [3:0]            rem_next;
    logic                  div_last;
    logic [4:0]            base_in;
    logic                  neg_in;
    logic [VALUE_BITS-1:0] mag_in;
    logic [LW-1:0]         len;
    logic [PW-1:0]         npad;
    logic                  wr_en;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    // Restoring division, one quotient bit per step; remainder stays below 16.
    always_comb
    begin
        logic [DW-1:0] m;
        logic [3:0]    r;
        logic [4:0]    t;
        m = mag_reg;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS_PER_CYC; i++)
        begin
            t = {r, m[DW-1]};
            m = {m[DW-2:0], 1'b0};
            if (t >= base_reg)
            begin
                t    = t - base_reg;
                m[0] = 1'b1;
            end
            r = t[3:0];
        end
        mag_next = m;
        rem_next = r;
    end

    assign div_last = (step_reg == SW'(DIV_CYC - 1));
    // out-of-range radix falls back to decimal, sign included
    assign base_in  = ((radix < RADIX_MIN) || (radix > RADIX_MAX)) ? RADIX_DEC : radix;
    assign neg_in   = (base_in == RADIX_DEC) && signed_mode && value[VALUE_BITS-1];
    assign mag_in   = neg_in ? (~value + 1'b1) : value;

    assign len  = LW'(nd_reg) + LW'(neg_reg);
    assign npad = (LW'(pad_reg) > len) ? PW'(LW'(pad_reg) - len) : '0;

    assign wr_en   = cmd.div_step && div_last;
    assign rd_en   = cmd.fetch || (cmd.emit_digit && (rd_idx_reg != '0));
    assign rd_addr = cmd.fetch ? AW'(nd_reg - CW'(1)) : (rd_idx_reg - AW'(1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dig_mem[nd_reg[AW-1:0]] <= rem_next;
        end
        if (rd_en)
        begin
            rd_data_reg <= dig_mem[rd_addr];
        end
    end

    // Operand and working payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg   <= DW'(mag_in);
            rem_reg   <= '0;
            neg_reg   <= neg_in;
            upper_reg <= upper_case;
            base_reg  <= base_in;
            pad_reg   <= (32'(pad_width) > 32'(MAX_PAD)) ? PW'(MAX_PAD) : PW'(pad_width);
        end
        else if (cmd.div_step)
        begin
            mag_reg <= mag_next;
            rem_reg <= div_last ? 4'd0 : rem_next;
        end
        if (cmd.emit_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_pad)
        begin
            char_reg <= CHAR_ZERO;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= digit_char(rd_data_reg, upper_reg);
            last_reg <= (rd_idx_reg == '0);
        end
    end

    // Counters and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            nd_reg      <= '0;
            rd_idx_reg  <= '0;
            pad_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_sign || cmd.emit_pad || cmd.emit_digit;
            if (cmd.load)
            begin
                step_reg <= '0;
                nd_reg   <= '0;
            end
            else if (cmd.div_step)
            begin
                if (div_last)
                begin
                    step_reg <= '0;
                    nd_reg   <= nd_reg + CW'(1);
                end
                else
                begin
                    step_reg <= step_reg + SW'(1);
                end
            end
            if (cmd.fetch)
            begin
                rd_idx_reg  <= AW'(nd_reg - CW'(1));
                pad_cnt_reg <= npad;
            end
            else
            begin
                if (cmd.emit_digit && (rd_idx_reg != '0))
                begin
                    rd_idx_reg <= rd_idx_reg - AW'(1);
                end
                if (cmd.emit_pad)
                begin
                    pad_cnt_reg <= pad_cnt_reg - PW'(1);
                end
            end
        end
    end

    // only looked at while dividing
    assign stat.div_done = div_last && (mag_next == '0);
    assign stat.neg      = neg_reg;
    assign stat.pad_zero = (pad_cnt_reg == '0);
    assign stat.idx_zero = (rd_idx_reg == '0);

    assign ascii_char = char_reg;
    assign last       = last_reg;
    assign strobe     = strobe_reg;

    `ASSERT_IMPL(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd))
    `ASSERT_IMPL(a_digit_room, clk, rst_n, wr_en, nd_reg < CW'(VALUE_BITS))
    `ASSERT_NEXT(a_final_last, clk, rst_n, cmd.emit_digit && stat.idx_zero, strobe_reg && last_reg)

endmodule

// ----- hw/rtl/integer_to_ascii_formatter.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one integer as ASCII text: optional minus, zero pad, digits.
//
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// input    | start & !busy        | value, radix, signed_mode, upper_case,
//          |                      | pad_width
// result   | strobe (one cycle)   | ascii_char, last
//
// Per number: accept, one division pass per digit, digit fetch, optional sign,
// pad zeros, then the digits from most significant down.
// The iterative radix divider (8 quotient bits per cycle) forms each digit;
// characters follow once all digits are stored.
// busy is high from the accepted start until the last character is issued.
// Results cannot be stalled. rst_n clears control.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_PAD    = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [4:0]            radix,
    input  logic                  signed_mode,
    input  logic                  upper_case,
    input  logic [4:0]            pad_width,
    output logic                  strobe,
    output logic [6:0]            ascii_char,
    output logic                  last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    itoa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    itoa_datapath
    #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_PAD    (MAX_PAD)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .radix       (radix),
        .signed_mode (signed_mode),
        .upper_case  (upper_case),
        .pad_width   (pad_width),
        .cmd         (cmd),
        .stat        (stat),
        .ascii_char  (ascii_char),
        .last        (last),
        .strobe      (strobe)
    );

endmodule
